### sv/dfbp_pkg.sv
package dfbp_pkg;

	localparam int STORE_DEPTH_DEF = 16384;
	localparam int PACKET_BYTES = 2052;
	localparam int HEADER_BYTES = 4;
	localparam int ADDR_W = 15;
	localparam int INDEX_W = 12;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int CFG_DATA_W = 2;

	localparam logic [7:0] SYNC_BYTE0 = 8'h81;
	localparam logic [7:0] SYNC_BYTE1 = 8'hC3;
	localparam logic [7:0] SYNC_BYTE2 = 8'hE7;
	localparam logic [7:0] CMD_BYTE = 8'h00;

	// Row pitches and tap offsets of the rescaled source frames.
	localparam logic [ADDR_W-1:0] PITCH_192 = ADDR_W'(192);
	localparam logic [ADDR_W-1:0] PITCH_256 = ADDR_W'(256);

	typedef enum logic [1:0] {
		FMT_128X16 = 2'd0,
		FMT_128X32 = 2'd1,
		FMT_192X64 = 2'd2,
		FMT_256X64 = 2'd3
	} fmt_t;

	typedef enum logic {
		SHADE_FOUR = 1'b0,
		SHADE_SIXTEEN = 1'b1
	} shade_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_FETCH = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_FORMAT = 1'b0,
		CFG_SHADE = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_FE_RUN,
		ST_FE_LAST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic frame_changed;
		logic [7:0] data_byte;
	} res_t;

	function automatic logic [7:0] header_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = SYNC_BYTE0;
			2'd1: b = SYNC_BYTE1;
			2'd2: b = SYNC_BYTE2;
			default: b = CMD_BYTE;
		endcase
		return b;
	endfunction

	// Four-shade panels show 3 at full brightness and 2 as a dim level.
	function automatic logic [3:0] shade_map(input logic [3:0] px, input shade_t mode);
		logic [3:0] r;
		r = px;
		if (mode == SHADE_FOUR) begin
			if (px == 4'd3)
				r = 4'd15;
			else if (px == 4'd2)
				r = 4'd4;
		end
		return r;
	endfunction

endpackage

### sv/dfbp_store.sv
module dfbp_store #(
	parameter int DEPTH = dfbp_pkg::STORE_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] addr,
	input logic [3:0] wdata,
	output logic [3:0] rdata
);

	logic [3:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

### sv/dfbp_engine.sv
module dfbp_engine #(
	parameter int STORE_DEPTH = dfbp_pkg::STORE_DEPTH_DEF,
	parameter int AW = $clog2(STORE_DEPTH),
	parameter int FW = $clog2(STORE_DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dfbp_pkg::cmd_t in_cmd,
	input logic [3:0] in_pixel,
	input logic in_last,
	input logic [dfbp_pkg::INDEX_W-1:0] in_index,
	input dfbp_pkg::fmt_t frame_format,
	input dfbp_pkg::shade_t shade_mode,
	output logic mem_we,
	output logic [AW-1:0] mem_addr,
	output logic [3:0] mem_wdata,
	input logic [3:0] mem_rdata,
	output logic res_valid,
	input logic res_ready,
	output dfbp_pkg::res_t res
);
	import dfbp_pkg::*;

	state_t state_q, state_d;

	// Load side state. Entries at or above fill_q have never been written and read as zero.
	logic [AW-1:0] pos_q;
	logic [FW-1:0] fill_q;
	logic differ_q;
	logic [3:0] pixel_q;
	logic last_q;

	// Fetch side state.
	logic [1:0] plane_q;
	logic [4:0] row_q;
	logic [3:0] colhi_q;
	logic [4:0] step_q;
	logic [5:0] sum_q;
	logic [7:0] acc_q;
	logic changed_q;

	logic run_s1;
	logic use_s1;
	logic [4:0] step_s1;

	// Tap address generation.
	logic [6:0] col;
	logic [1:0] tap;
	logic [4:0] row_m8;
	logic [8:0] col3;
	logic [ADDR_W-1:0] base2, base3, off2, off3, tap_addr;
	logic tap_on, tap_use;

	always_comb begin
		col = {colhi_q, step_q[4:2]};
		tap = step_q[1:0];
		row_m8 = row_q - 5'd8;
		col3 = {2'b00, col} + {1'b0, col, 1'b0};
		base2 = ADDR_W'({row_q, 8'd0}) + ADDR_W'({row_q, 7'd0}) + ADDR_W'(col3[8:1]);
		base3 = ADDR_W'({row_q, 9'd0}) + ADDR_W'({col, 1'b0});
		unique case (tap)
			2'd0: begin off2 = '0; off3 = '0; end
			2'd1: begin off2 = PITCH_192; off3 = PITCH_256; end
			2'd2: begin off2 = ADDR_W'(1); off3 = ADDR_W'(1); end
			default: begin off2 = PITCH_192 + ADDR_W'(1); off3 = PITCH_256 + ADDR_W'(1); end
		endcase
		unique case (frame_format)
			FMT_128X16: begin
				tap_addr = ADDR_W'({row_m8[3:0], col});
				tap_on = (tap == 2'd0) && (row_q >= 5'd8) && (row_q <= 5'd23);
			end
			FMT_128X32: begin
				tap_addr = ADDR_W'({row_q, col});
				tap_on = (tap == 2'd0);
			end
			FMT_192X64: begin
				tap_addr = base2 + off2;
				// An even column averages only the pixel and the one below it.
				tap_on = col[0] || !tap[1];
			end
			default: begin
				tap_addr = base3 + off3;
				tap_on = 1'b1;
			end
		endcase
		tap_use = tap_on && (tap_addr < ADDR_W'(fill_q));
	end

	// Pixel reduction once the fourth tap of a column has arrived.
	logic [3:0] tap_val;
	logic [5:0] sum_all;
	logic [3:0] px, px_mapped;

	always_comb begin
		tap_val = use_s1 ? mem_rdata : 4'd0;
		sum_all = sum_q + 6'(tap_val);
		unique case (frame_format)
			FMT_192X64: px = step_s1[2] ? sum_all[5:2] : sum_all[4:1];
			FMT_256X64: px = sum_all[5:2];
			default: px = sum_all[3:0];
		endcase
		px_mapped = shade_map(px, shade_mode);
	end

	// Load compare.
	logic old_valid, differs;
	logic [AW-1:0] pos_next;
	logic [FW-1:0] pos_inc;

	always_comb begin
		old_valid = FW'(pos_q) < fill_q;
		differs = (old_valid ? mem_rdata : 4'd0) != pixel_q;
		pos_inc = FW'(pos_q) + FW'(1);
		pos_next = (pos_inc == FW'(STORE_DEPTH)) ? '0 : pos_inc[AW-1:0];
	end

	// Index decode at acceptance.
	logic [INDEX_W-1:0] pidx;
	logic idx_header, idx_past;

	always_comb begin
		pidx = in_index - INDEX_W'(HEADER_BYTES);
		idx_header = in_index < INDEX_W'(HEADER_BYTES);
		idx_past = in_index >= INDEX_W'(PACKET_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mem_we = 1'b0;
		mem_addr = pos_q;
		mem_wdata = pixel_q;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == CMD_LOAD)
						state_d = ST_LD_RD;
					else if (idx_header || idx_past)
						state_d = ST_DONE;
					else
						state_d = ST_FE_RUN;
				end
			end
			ST_LD_RD: state_d = ST_LD_WR;
			ST_LD_WR: begin
				mem_we = 1'b1;
				state_d = ST_DONE;
			end
			ST_FE_RUN: begin
				mem_addr = tap_addr[AW-1:0];
				if (step_q == 5'd31)
					state_d = ST_FE_LAST;
			end
			ST_FE_LAST: state_d = ST_DONE;
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fill_q <= '0;
			differ_q <= 1'b0;
			run_s1 <= 1'b0;
		end else begin
			run_s1 <= (state_q == ST_FE_RUN);
			if (state_q == ST_LD_WR) begin
				pos_q <= last_q ? '0 : pos_next;
				differ_q <= last_q ? 1'b0 : (differ_q | differs);
				if (pos_inc > fill_q)
					fill_q <= pos_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		use_s1 <= tap_use;
		step_s1 <= step_q;
		if (state_q == ST_IDLE && in_valid) begin
			pixel_q <= in_pixel;
			last_q <= in_last;
			changed_q <= 1'b0;
			plane_q <= pidx[10:9];
			row_q <= pidx[8:4];
			colhi_q <= pidx[3:0];
			step_q <= '0;
			sum_q <= '0;
			if (in_cmd == CMD_FETCH && idx_header)
				acc_q <= header_byte(in_index[1:0]);
			else
				acc_q <= '0;
		end
		if (state_q == ST_LD_WR)
			changed_q <= last_q & (differ_q | differs);
		if (state_q == ST_FE_RUN)
			step_q <= step_q + 5'd1;
		if (run_s1) begin
			if (step_s1[1:0] == 2'd3) begin
				acc_q[step_s1[4:2]] <= px_mapped[plane_q];
				sum_q <= '0;
			end else begin
				sum_q <= sum_all;
			end
		end
	end

	assign res.frame_changed = changed_q;
	assign res.data_byte = acc_q;

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= $past(fill_q))
		else $error("fill count shrank");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STORE_DEPTH) && FW'(pos_q) < FW'(STORE_DEPTH))
		else $error("load position or fill count beyond the store");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(acc_q) && $stable(changed_q))
		else $error("result changed while stalled");

	a_last_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FE_LAST |-> $past(state_q) == ST_FE_RUN)
		else $error("fetch finished without running its reads");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted item did not start");

endmodule

### sv/dmd_frame_bitplane_packer_unit.sv
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    command, pixel, last_pixel, byte_index
// m_*       out        m_tvalid / m_tready    frame_changed, data_byte
// cfg_*     in         cfg_valid / cfg_ready  register index, write data
//
// A load passes through acceptance, a read of the old entry, compare and write back,
// then hand-over of the result. A header or out-of-range fetch skips to hand-over.
// A bitplane fetch is paced by the 32 reads (eight columns, four taps each)
// on the single store port.
// Reset needs no clearing pass: a fill count marks the written prefix of the store.
// A new item is taken while a finished result waits in the output register.
module dmd_frame_bitplane_packer_unit #(
	parameter int STORE_DEPTH = dfbp_pkg::STORE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [dfbp_pkg::S_TDATA_W-1:0] s_tdata,  // [3:0] pixel, [15:4] byte_index
	input logic s_tlast,                            // last_pixel
	input logic s_tuser,                            // command
	output logic m_tvalid,
	input logic m_tready,
	output logic [dfbp_pkg::M_TDATA_W-1:0] m_tdata, // [0] frame_changed, [8:1] data_byte, zero
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [dfbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dfbp_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	fmt_t format_q;
	shade_t shade_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_128X32;
			shade_q <= SHADE_SIXTEEN;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FORMAT: format_q <= fmt_t'(cfg_data);
				CFG_SHADE: shade_q <= shade_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [3:0] mem_wdata, mem_rdata;
	logic res_valid, res_ready;
	res_t res;

	dfbp_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	dfbp_engine #(.STORE_DEPTH(STORE_DEPTH)) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_cmd(cmd_t'(s_tuser)),
		.in_pixel(s_tdata[3:0]),
		.in_last(s_tlast),
		.in_index(s_tdata[15:4]),
		.frame_format(format_q),
		.shade_mode(shade_q),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_valid && res_ready)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			m_tdata_q <= M_TDATA_W'({res.data_byte, res.frame_changed});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import dfbp_pkg::*;

	// A reduced store makes the rescaled formats read past the end of the store.
	localparam int TB_DEPTH = 4096;
	localparam int PLANE_LEN = 512;
	localparam int LONG_FRAME = 256;

	typedef struct {
		logic frame_changed;
		logic [7:0] data_byte;
	} panel_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;  // [3:0] pixel, [15:4] byte_index
	logic s_tlast;                  // last_pixel
	logic s_tuser;                  // command
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;  // [0] frame_changed, [8:1] data_byte, zero above
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Mirror of the block's state.
	logic [3:0] shadow_store [TB_DEPTH];
	int unsigned fill_pos;
	bit diff_flag;
	fmt_t cur_fmt;
	shade_t cur_shade;

	panel_out_t outputs_due [$];
	int error_count = 0;
	bit src_gaps_on = 1'b1;
	bit snk_stalls_on = 1'b1;

	dmd_frame_bitplane_packer_unit #(
		.STORE_DEPTH(TB_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned stored_px(input int unsigned addr);
		return (addr < TB_DEPTH) ? int'(shadow_store[addr]) : 0;
	endfunction

	// Shade shown at panel position (row, col) after rescaling and remapping.
	function automatic logic [3:0] shown_shade(input int unsigned row, input int unsigned col);
		int unsigned base;
		int unsigned sum;
		logic [3:0] px;
		case (cur_fmt)
			FMT_128X16: begin
				if (row < 8 || row > 23)
					return 4'd0;
				sum = stored_px((row - 8) * 128 + col);
			end
			FMT_192X64: begin
				base = row * 384 + (col * 3) / 2;
				if (col[0])
					sum = (stored_px(base) + stored_px(base + 1) + stored_px(base + 192)
						+ stored_px(base + 193)) / 4;
				else
					sum = (stored_px(base) + stored_px(base + 192)) / 2;
			end
			FMT_256X64: begin
				base = row * 512 + col * 2;
				sum = (stored_px(base) + stored_px(base + 1) + stored_px(base + 256)
					+ stored_px(base + 257)) / 4;
			end
			default: sum = stored_px(row * 128 + col);
		endcase
		px = sum[3:0];
		if (cur_shade == SHADE_FOUR) begin
			if (px == 4'd3)
				px = 4'd15;
			else if (px == 4'd2)
				px = 4'd4;
		end
		return px;
	endfunction

	function automatic logic [7:0] packet_byte_at(input int unsigned idx);
		int unsigned off;
		int unsigned plane;
		int unsigned plane_off;
		int unsigned row;
		int unsigned col0;
		logic [3:0] px;
		logic [7:0] acc;
		case (idx)
			0: return SYNC_BYTE0;
			1: return SYNC_BYTE1;
			2: return SYNC_BYTE2;
			3: return CMD_BYTE;
			default: ;
		endcase
		if (idx >= PACKET_BYTES)
			return 8'h00;
		off = idx - HEADER_BYTES;
		plane = off / PLANE_LEN;
		plane_off = off % PLANE_LEN;
		row = plane_off / 16;
		col0 = (plane_off % 16) * 8;
		acc = 8'h00;
		for (int v = 0; v < 8; v++) begin
			px = shown_shade(row, col0 + v);
			acc[v] = px[plane];
		end
		return acc;
	endfunction

	// Applies one accepted item to the mirrored state and returns its output.
	function automatic panel_out_t pack_or_load(input cmd_t cmd, input logic [3:0] pix,
			input logic last, input logic [11:0] idx);
		panel_out_t r;
		r.frame_changed = 1'b0;
		r.data_byte = 8'h00;
		if (cmd == CMD_FETCH) begin
			r.data_byte = packet_byte_at(idx);
			return r;
		end
		if (fill_pos >= TB_DEPTH)
			fill_pos = 0;
		if (shadow_store[fill_pos] != pix)
			diff_flag = 1'b1;
		shadow_store[fill_pos] = pix;
		fill_pos = (fill_pos + 1 >= TB_DEPTH) ? 0 : fill_pos + 1;
		if (last) begin
			r.frame_changed = diff_flag;
			diff_flag = 1'b0;
			fill_pos = 0;
		end
		return r;
	endfunction

	// Called and left at a falling edge.
	task automatic send_item(input cmd_t cmd, input logic [3:0] pix, input logic last,
			input logic [11:0] idx);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tlast = last;
		s_tdata = {idx, pix};
		do
			@(posedge clk);
		while (!s_tready);
		outputs_due.push_back(pack_or_load(cmd, pix, last, idx));
		@(negedge clk);
	endtask

	task automatic load_pixel(input logic [3:0] pix, input logic last);
		send_item(CMD_LOAD, pix, last, 12'($urandom_range(0, 4095)));
	endtask

	task automatic fetch_byte(input logic [11:0] idx);
		send_item(CMD_FETCH, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), idx);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (outputs_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_FORMAT: cur_fmt = fmt_t'(val);
			default: cur_shade = shade_t'(val[0]);
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_header_bytes();
		fetch_byte(12'd0);
		fetch_byte(12'd1);
		fetch_byte(12'd2);
		fetch_byte(12'd3);
		fetch_byte(12'd2051);
		fetch_byte(12'd2052);
		fetch_byte(12'd4095);
	endtask

	task automatic test_frame_changes();
		// An all-zero pixel over a fresh store is no change; the next one differs and the last repeats it.
		load_pixel(4'd0, 1'b1);
		load_pixel(4'd15, 1'b1);
		load_pixel(4'd15, 1'b1);
	endtask

	task automatic test_shade_remap();
		load_pixel(4'd3, 1'b0);
		load_pixel(4'd2, 1'b0);
		load_pixel(4'd1, 1'b0);
		load_pixel(4'd15, 1'b1);
		wait_drained();
		write_reg(CFG_SHADE, {1'b0, SHADE_FOUR});
		for (int p = 0; p < 4; p++)
			fetch_byte(12'(HEADER_BYTES + p * PLANE_LEN));
	endtask

	task automatic test_narrow_frame();
		wait_drained();
		write_reg(CFG_FORMAT, FMT_128X16);
		fetch_byte(12'(HEADER_BYTES));
		fetch_byte(12'(HEADER_BYTES + 8 * 16));
		fetch_byte(12'(HEADER_BYTES + 23 * 16 + 3 * PLANE_LEN));
	endtask

	// Leaves random content over the first 256 entries of the store for the rescaled reads.
	task automatic test_long_frame();
		wait_drained();
		src_gaps_on = 1'b0;
		snk_stalls_on = 1'b0;
		for (int k = 0; k < LONG_FRAME; k++)
			load_pixel(4'($urandom_range(0, 15)), k == LONG_FRAME - 1);
		wait_drained();
		src_gaps_on = 1'b1;
		snk_stalls_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int sent;
		int len;
		int kind;
		bit same;
		logic [3:0] pix;
		logic [11:0] idx;
		for (int f = 0; f < 4; f++) begin
			for (int s = 0; s < 2; s++) begin
				wait_drained();
				write_reg(CFG_FORMAT, CFG_DATA_W'(f));
				write_reg(CFG_SHADE, {1'($urandom_range(0, 1)), 1'(s)});
				sent = 0;
				while (sent < 40) begin
					kind = $urandom_range(0, 9);
					if (kind <= 3) begin
						len = $urandom_range(1, 8);
						for (int k = 0; k < len; k++) begin
							case ($urandom_range(0, 9))
								0: idx = 12'($urandom_range(0, 3));
								1: idx = 12'($urandom_range(PACKET_BYTES, 4095));
								default: idx = 12'($urandom_range(HEADER_BYTES, PACKET_BYTES - 1));
							endcase
							fetch_byte(idx);
						end
						sent += len;
					end else if (kind <= 6) begin
						// A whole short frame, often rewriting what the store already holds.
						len = $urandom_range(1, 48);
						same = ($urandom_range(0, 2) == 0);
						for (int k = 0; k < len; k++) begin
							if (same)
								pix = shadow_store[fill_pos % TB_DEPTH];
							else
								pix = 4'($urandom_range(0, 15));
							load_pixel(pix, k == len - 1);
						end
						sent += len;
					end else if (kind == 7) begin
						len = $urandom_range(1, 5);
						for (int k = 0; k < len; k++)
							load_pixel(4'($urandom_range(0, 15)), 1'b0);
						sent += len;
					end else if (kind == 8) begin
						src_gaps_on = !src_gaps_on;
					end else begin
						snk_stalls_on = !snk_stalls_on;
					end
				end
			end
		end
	endtask

	// Output ready with random stalls before each transfer.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = snk_stalls_on ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		panel_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (outputs_due.size() == 0) begin
				$error("output transfer with nothing outstanding: tdata %h", m_tdata);
				error_count++;
			end else begin
				want = outputs_due.pop_front();
				if (m_tdata[0] !== want.frame_changed) begin
					$error("frame_changed: expected %0d, got %0d", want.frame_changed, m_tdata[0]);
					error_count++;
				end
				if (m_tdata[8:1] !== want.data_byte) begin
					$error("data_byte: expected %02h, got %02h", want.data_byte, m_tdata[8:1]);
					error_count++;
				end
				if (m_tdata[M_TDATA_W-1:9] !== '0) begin
					$error("padding: expected 0, got %0h", m_tdata[M_TDATA_W-1:9]);
					error_count++;
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		for (int a = 0; a < TB_DEPTH; a++)
			shadow_store[a] = 4'd0;
		fill_pos = 0;
		diff_flag = 1'b0;
		cur_fmt = FMT_128X32;
		cur_shade = SHADE_SIXTEEN;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_header_bytes();
		test_frame_changes();
		test_shade_remap();
		test_narrow_frame();
		test_long_frame();
		test_random_traffic();

		wait_drained();
		repeat (64) @(negedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
